// ===== rtl/label_char_entropy_macros.svh =====
// ----------------------------------------------------------------------------
// label char entropy assertion macros
// shared property shapes for the label entropy block
// ----------------------------------------------------------------------------
`ifndef LABEL_CHAR_ENTROPY_MACROS_SVH
`define LABEL_CHAR_ENTROPY_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LCE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lce assertion failed");
`define LCE_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lce assertion failed");
`else
`define LCE_ASSERT_IMP(name, ante, cons)
`define LCE_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== rtl/lce_pkg.sv =====
// ----------------------------------------------------------------------------
// lce_pkg
// constants, types and the log2 table of the label entropy block
// ----------------------------------------------------------------------------
package lce_pkg;

    localparam int unsigned MAX_LEN     = 63;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned CODES       = 1 << CODE_W;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned LOG_FRAC    = 28;
    localparam int unsigned LOG_W       = LOG_FRAC + 3;
    localparam int unsigned PROD_W      = CNT_W + LOG_W;
    localparam int unsigned ACC_W       = PROD_W + 1;
    localparam int unsigned HUNDRED     = 100;
    localparam int unsigned SCL_W       = ACC_W + 7;
    localparam int unsigned T_W         = SCL_W - LOG_FRAC;
    localparam int unsigned STEP_W      = $clog2(T_W + 1);
    localparam int unsigned ENT_W       = 10;
    localparam int unsigned ENTROPY_MAX = 800;
    localparam int unsigned LST_IW      = $clog2(MAX_LEN);
    localparam int unsigned DIST_W      = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_TOTAL,
        ALU_MAC,
        ALU_SCALE,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [CODE_W-1:0] rd_code;
        logic              wr_en;
        logic [CODE_W-1:0] wr_code;
        logic [CNT_W-1:0]  wr_count;
        logic              lst_wr_en;
        logic [LST_IW-1:0] lst_wr_idx;
        logic [LST_IW-1:0] lst_rd_idx;
    } t_hist_req;

    typedef logic [LOG_W-1:0] t_log_tab [CODES];

    // log2 in q.28: integer part plus fraction by repeated squaring
    function automatic logic [LOG_W-1:0] log2_fix(input int unsigned x);
        longint unsigned y;
        longint unsigned frac;
        int unsigned     k;
        k    = 0;
        frac = 0;
        if (x == 0) begin
            return '0;
        end
        for (int j = 0; j < 31; j++) begin
            if ((x >> (j + 1)) != 0) begin
                k = j + 1;
            end
        end
        y = longint'(x) << (31 - k);
        for (int i = 0; i < LOG_FRAC; i++) begin
            y    = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32)) begin
                frac = frac | 64'd1;
                y    = y >> 1;
            end
        end
        return LOG_W'((longint'(k) << LOG_FRAC) | frac);
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab tab;
        for (int i = 0; i < CODES; i++) begin
            tab[i] = log2_fix(i);
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

endpackage

// ===== rtl/lce_hist.sv =====
// ----------------------------------------------------------------------------
// lce_hist
// character count memory with per-entry valid bits and distinct code list
// ----------------------------------------------------------------------------
module lce_hist import lce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hist_req         i_req,
    output logic [CNT_W-1:0]  o_count,
    output logic [CODE_W-1:0] o_lst_code
);

    logic [CNT_W-1:0]  r_mem [CODES];
    logic [CODE_W-1:0] r_lst [MAX_LEN];
    logic [CODES-1:0]  r_vld;
    logic              r_rd_vld;
    logic [CNT_W-1:0]  r_rd_data;
    logic [CODE_W-1:0] r_lst_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_req.clear) begin
            r_vld <= '0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_code] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_code];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_code] <= i_req.wr_count;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.lst_wr_en) begin
            r_lst[i_req.lst_wr_idx] <= i_req.wr_code;
        end
        r_lst_data <= r_lst[i_req.lst_rd_idx];
    end

    assign o_count    = r_rd_vld ? r_rd_data : '0;
    assign o_lst_code = r_lst_data;

endmodule

// ===== rtl/lce_alu.sv =====
// ----------------------------------------------------------------------------
// lce_alu
// shared multiply-accumulate, scale and restoring divide step unit
// ----------------------------------------------------------------------------
module lce_alu import lce_pkg::*; (
    input  logic             i_clk,
    input  t_alu_op          i_op,
    input  logic [CNT_W-1:0] i_len,
    input  logic [CNT_W-1:0] i_cnt,
    output logic [T_W-1:0]   o_quo
);

    logic [PROD_W-1:0] r_total;
    logic [ACC_W-1:0]  r_parts;
    logic [T_W-1:0]    r_dvd;
    logic [CNT_W-1:0]  r_rem;

    logic [CNT_W-1:0]  mul_arg;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  s_val;
    logic [SCL_W-1:0]  scaled;
    logic [CNT_W:0]    rem_sh;
    logic              ge;

    assign mul_arg = (i_op == ALU_TOTAL) ? i_len : i_cnt;
    assign prod    = PROD_W'(mul_arg) * PROD_W'(LOG_TAB[mul_arg]);
    assign s_val   = (ACC_W'(r_total) > r_parts) ? (ACC_W'(r_total) - r_parts) : '0;
    assign scaled  = SCL_W'(s_val) * SCL_W'(HUNDRED);
    assign rem_sh  = {r_rem, r_dvd[T_W-1]};
    assign ge      = rem_sh >= {1'b0, i_len};

    always_ff @(posedge i_clk) begin
        case (i_op)
            ALU_TOTAL: begin
                r_total <= prod;
                r_parts <= '0;
            end
            ALU_MAC: begin
                r_parts <= r_parts + ACC_W'(prod);
            end
            ALU_SCALE: begin
                r_dvd <= scaled[SCL_W-1:LOG_FRAC];
                r_rem <= '0;
            end
            ALU_DIV: begin
                r_rem <= ge ? CNT_W'(rem_sh - {1'b0, i_len}) : CNT_W'(rem_sh);
                r_dvd <= {r_dvd[T_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    assign o_quo = r_dvd;

endmodule

// ===== rtl/label_char_entropy.sv =====
// ----------------------------------------------------------------------------
// label_char_entropy
// shannon entropy of the character histogram of one label, in hundredths
// ----------------------------------------------------------------------------
// a character item is a count read, then a count write
// a last item's entropy comes from the shared multiply unit walking the list
// of distinct characters, then 19 divide steps
// an empty-label or too-long last item goes straight to the emit state
// reset is synchronous, active low, clears control state and the count valid
// bits at once; no clearing pass
// ----------------------------------------------------------------------------
`include "label_char_entropy_macros.svh"

module label_char_entropy import lce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic              i_is_last,
    input  logic              i_empty_label,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ENT_W-1:0]  o_entropy_hundredths,
    output logic              o_label_too_long
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_TOT,
        S_LRD,
        S_HRD,
        S_MAC,
        S_SCALE,
        S_DIV,
        S_RES,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_len;
    logic              r_ovf;
    logic [DIST_W-1:0] r_distinct;
    logic [LST_IW-1:0] r_widx;
    logic [STEP_W-1:0] r_step;
    logic [CODE_W-1:0] r_code;
    logic              r_last;
    logic [ENT_W-1:0]  r_res_ent;
    logic              r_res_ovf;
    logic              r_ov;
    logic [ENT_W-1:0]  r_out_ent;
    logic              r_out_ovf;

    t_hist_req         hreq;
    logic [CNT_W-1:0]  count;
    logic [CODE_W-1:0] lst_code;
    t_alu_op           alu_op;
    logic [T_W-1:0]    quo;
    logic [ENT_W-1:0]  sat;
    logic              room;
    logic              emit_ok;

    assign room    = r_len < CNT_W'(MAX_LEN);
    assign emit_ok = !r_ov || !i_stall;
    assign sat     = (quo > T_W'(ENTROPY_MAX)) ? ENT_W'(ENTROPY_MAX) : quo[ENT_W-1:0];

    lce_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (hreq),
        .o_count    (count),
        .o_lst_code (lst_code)
    );

    lce_alu u_alu (
        .i_clk (i_clk),
        .i_op  (alu_op),
        .i_len (r_len),
        .i_cnt (count),
        .o_quo (quo)
    );

    always_comb begin
        hreq   = '0;
        alu_op = ALU_NOP;
        case (r_state)
            S_IDLE: begin
                hreq.rd_en   = i_valid && !i_empty_label && room;
                hreq.rd_code = i_char_code;
            end
            S_INC: begin
                hreq.wr_en      = 1'b1;
                hreq.wr_code    = r_code;
                hreq.wr_count   = count + 1'b1;
                hreq.lst_wr_en  = (count == '0);
                hreq.lst_wr_idx = r_distinct[LST_IW-1:0];
            end
            S_TOT: begin
                alu_op = ALU_TOTAL;
            end
            S_LRD: begin
                hreq.lst_rd_idx = r_widx;
            end
            S_HRD: begin
                hreq.rd_en   = 1'b1;
                hreq.rd_code = lst_code;
            end
            S_MAC: begin
                alu_op = ALU_MAC;
            end
            S_SCALE: begin
                alu_op = ALU_SCALE;
            end
            S_DIV: begin
                alu_op = ALU_DIV;
            end
            S_EMIT: begin
                hreq.clear = emit_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_distinct <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (r_state == S_EMIT && emit_ok) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_code <= i_char_code;
                        r_last <= i_is_last;
                        if (i_empty_label) begin
                            r_res_ent <= '0;
                            r_res_ovf <= r_ovf;
                            r_state   <= S_EMIT;
                        end else if (!room) begin
                            r_ovf <= 1'b1;
                            if (i_is_last) begin
                                r_res_ent <= '0;
                                r_res_ovf <= 1'b1;
                                r_state   <= S_EMIT;
                            end
                        end else begin
                            r_state <= S_INC;
                        end
                    end
                end
                S_INC: begin
                    r_len <= r_len + 1'b1;
                    if (count == '0) begin
                        r_distinct <= r_distinct + 1'b1;
                    end
                    r_state <= r_last ? S_TOT : S_IDLE;
                end
                S_TOT: begin
                    r_widx  <= '0;
                    r_state <= S_LRD;
                end
                S_LRD: begin
                    r_state <= S_HRD;
                end
                S_HRD: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (DIST_W'(r_widx) + DIST_W'(1) == r_distinct) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_widx  <= r_widx + 1'b1;
                        r_state <= S_LRD;
                    end
                end
                S_SCALE: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(T_W - 1)) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    r_res_ent <= sat;
                    r_res_ovf <= 1'b0;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_out_ent  <= r_res_ent;
                        r_out_ovf  <= r_res_ovf;
                        r_len      <= '0;
                        r_ovf      <= 1'b0;
                        r_distinct <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall              = (r_state != S_IDLE);
    assign o_valid              = r_ov;
    assign o_entropy_hundredths = r_out_ent;
    assign o_label_too_long     = r_out_ovf;

    `LCE_ASSERT_IMP(a_len_bound, 1'b1, r_len <= CNT_W'(MAX_LEN))
    `LCE_ASSERT_IMP(a_distinct_le_len, 1'b1, DIST_W'(r_len) >= r_distinct)
    `LCE_ASSERT_IMP(a_long_is_zero, o_valid && o_label_too_long, o_entropy_hundredths == '0)
    `LCE_ASSERT_IMP(a_ent_bound, o_valid, o_entropy_hundredths <= ENT_W'(ENTROPY_MAX))
    `LCE_ASSERT_NXT(a_res_clears, r_state == S_EMIT && emit_ok,
                    r_len == '0 && r_distinct == '0 && !r_ovf)

endmodule

// ===== dv/tb_label_char_entropy.sv =====
// ----------------------------------------------------------------------------
// tb_label_char_entropy
// self-checking bench for the label entropy block: a table of directed labels,
// then random labels (short, long, all distinct, too long, cut off by an empty
// label), each result checked field by field against a pinned value or an in-bench
// predictor of the histogram entropy; random idling on both valid/stall channels
// ----------------------------------------------------------------------------
module tb_label_char_entropy;
    import lce_pkg::*;

    localparam int          ITEM_TARGET = 900;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          END_WAIT    = 3 * MAX_LEN + 40;
    localparam int          DRAIN_EVERY = 97;

    typedef struct packed {
        logic [ENT_W-1:0] entropy;
        logic             too_long;
    } t_label_result;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
        logic              empty;
        logic [7:0]        reps;
        logic              pin;
        logic [ENT_W-1:0]  entropy;
        logic              too_long;
    } t_dir_row;

    localparam int N_ROWS = 19;
    localparam t_dir_row DIR_ROWS [N_ROWS] = '{
        // empty label right after reset
        '{8'h00, 1'b0, 1'b1, 8'd1, 1'b1, 10'd0, 1'b0},
        // single character
        '{8'h00, 1'b1, 1'b0, 8'd1, 1'b1, 10'd0, 1'b0},
        // one character repeated
        '{8'hff, 1'b1, 1'b0, 8'd3, 1'b1, 10'd0, 1'b0},
        '{8'h61, 1'b0, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'h62, 1'b1, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'h55, 1'b0, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'haa, 1'b0, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'h0f, 1'b0, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'hf0, 1'b1, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        // pending characters dropped by an empty label
        '{8'h78, 1'b0, 1'b0, 8'd2, 1'b0, 10'd0, 1'b0},
        '{8'h79, 1'b0, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'hff, 1'b1, 1'b1, 8'd1, 1'b1, 10'd0, 1'b0},
        // one character past the limit
        '{8'h7a, 1'b0, 1'b0, 8'(MAX_LEN), 1'b0, 10'd0, 1'b0},
        '{8'h7a, 1'b1, 1'b0, 8'd1, 1'b1, 10'd0, 1'b1},
        // too long, then ended by an empty label
        '{8'h6b, 1'b0, 1'b0, 8'(MAX_LEN + 7), 1'b0, 10'd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 8'd1, 1'b1, 10'd0, 1'b1},
        // exactly at the limit
        '{8'h63, 1'b0, 1'b0, 8'(MAX_LEN - 1), 1'b0, 10'd0, 1'b0},
        '{8'h64, 1'b1, 1'b0, 8'd1, 1'b0, 10'd0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 8'd1, 1'b1, 10'd0, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CODE_W-1:0] i_char_code;
    logic              i_is_last;
    logic              i_empty_label;
    logic              o_valid;
    logic              i_stall;
    logic [ENT_W-1:0]  o_entropy_hundredths;
    logic              o_label_too_long;

    logic [7:0]        char_hist [CODES];
    logic [7:0]        run_len;
    logic              over_flag;
    t_label_result     label_results [$];
    int                err_cnt   = 0;
    int                items_sent = 0;
    int                cycle_cnt = 0;
    bit                calm      = 1'b0;

    label_char_entropy dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_char_code          (i_char_code),
        .i_is_last            (i_is_last),
        .i_empty_label        (i_empty_label),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_entropy_hundredths (o_entropy_hundredths),
        .o_label_too_long     (o_label_too_long)
    );

    always begin
        #1 i_clk = 1'b0;
        #1 i_clk = 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 4));
    endfunction

    // log2 in q.28, fraction by repeated squaring of the mantissa
    function automatic logic [63:0] log2_q28(input logic [7:0] x);
        logic [63:0] m;
        logic [63:0] fr;
        int          msb;
        msb = 0;
        fr  = '0;
        for (int b = 0; b < 8; b++) begin
            if (x[b]) begin
                msb = b;
            end
        end
        m = 64'(x) << (31 - msb);
        repeat (LOG_FRAC) begin
            m  = (m * m) >> 31;
            fr = fr << 1;
            if (m[32]) begin
                fr = fr | 64'd1;
                m  = m >> 1;
            end
        end
        return (64'(msb) << LOG_FRAC) | fr;
    endfunction

    function automatic logic [ENT_W-1:0] label_entropy();
        logic [63:0] total;
        logic [63:0] parts;
        logic [63:0] s;
        logic [63:0] h;
        parts = '0;
        if (run_len == 0) begin
            return '0;
        end
        total = 64'(run_len) * log2_q28(run_len);
        for (int v = 0; v < CODES; v++) begin
            if (char_hist[v] != 0) begin
                parts = parts + 64'(char_hist[v]) * log2_q28(char_hist[v]);
            end
        end
        s = (total > parts) ? total - parts : 64'd0;
        h = (s * 64'(HUNDRED)) / (64'(run_len) << LOG_FRAC);
        if (h > 64'(ENTROPY_MAX)) begin
            h = 64'(ENTROPY_MAX);
        end
        return h[ENT_W-1:0];
    endfunction

    function automatic void clear_label();
        foreach (char_hist[v]) begin
            char_hist[v] = '0;
        end
        run_len   = '0;
        over_flag = 1'b0;
    endfunction

    // advance the histogram by one item; returns 1 when the label ends
    function automatic bit label_step(input logic [CODE_W-1:0] code, input logic last,
                                      input logic empty, output t_label_result res);
        res = '0;
        if (empty) begin
            res.too_long = over_flag;
            clear_label();
            return 1'b1;
        end
        if (run_len >= MAX_LEN) begin
            over_flag = 1'b1;
        end else begin
            char_hist[code] = char_hist[code] + 8'd1;
            run_len         = run_len + 8'd1;
        end
        if (!last) begin
            return 1'b0;
        end
        if (over_flag) begin
            res.too_long = 1'b1;
        end else begin
            res.entropy = label_entropy();
        end
        clear_label();
        return 1'b1;
    endfunction

    task automatic send_item(input logic [CODE_W-1:0] code, input logic last,
                             input logic empty, input logic pin,
                             input t_label_result pinned);
        int            gap;
        t_label_result res;
        gap = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_char_code   <= code;
        i_is_last     <= last;
        i_empty_label <= empty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (label_step(code, last, empty, res)) begin
            if (pin) begin
                res = pinned;
            end
            label_results = {label_results, res};
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (label_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall per item, then check against the oldest expectation
    initial begin
        int            w;
        t_label_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            w = draw_wait();
            if (w != 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (label_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: entropy %0d too_long %0b",
                                          o_entropy_hundredths, o_label_too_long));
            end else begin
                want = label_results.pop_front();
                if (o_entropy_hundredths !== want.entropy) begin
                    report_mismatch($sformatf("entropy_hundredths got %0d expected %0d",
                                              o_entropy_hundredths, want.entropy));
                end
                if (o_label_too_long !== want.too_long) begin
                    report_mismatch($sformatf("label_too_long got %0b expected %0b",
                                              o_label_too_long, want.too_long));
                end
            end
        end
    end

    initial begin
        int                kind;
        int                len;
        int                labels;
        bit                narrow;
        logic [CODE_W-1:0] base;
        logic [CODE_W-1:0] code;
        t_dir_row          row;
        labels        = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_char_code   = '0;
        i_is_last     = 1'b0;
        i_empty_label = 1'b0;
        i_stall       = 1'b0;
        clear_label();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            row = DIR_ROWS[r];
            for (int k = 0; k < int'(row.reps); k++) begin
                send_item(row.code, row.last && (k == int'(row.reps) - 1), row.empty,
                          row.pin, '{row.entropy, row.too_long});
            end
        end
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            calm   = ($urandom_range(0, 7) == 0);
            narrow = ($urandom_range(0, 2) == 0);
            base   = CODE_W'($urandom_range(0, 255));
            kind   = $urandom_range(0, 19);
            if (kind == 0) begin
                send_item(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                          1'b0, '0);
            end else if (kind == 1) begin
                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
                for (int k = 0; k < len; k++) begin
                    send_item(CODE_W'($urandom_range(0, 255)), k == len - 1, 1'b0, 1'b0, '0);
                end
            end else if (kind == 2) begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++) begin
                    send_item(CODE_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                end
                send_item(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                          1'b0, '0);
            end else if (kind == 3) begin
                // every character distinct
                len = $urandom_range(MAX_LEN - 8, MAX_LEN);
                for (int k = 0; k < len; k++) begin
                    send_item(base + CODE_W'(k), k == len - 1, 1'b0, 1'b0, '0);
                end
            end else begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_LEN)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    code = narrow ? base + CODE_W'($urandom_range(0, 3))
                                  : CODE_W'($urandom_range(0, 255));
                    send_item(code, k == len - 1, 1'b0, 1'b0, '0);
                end
            end
            labels++;
            if (labels % DRAIN_EVERY == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
